>>> rtl/eapm_pkg.sv
// Shared types and constants for the Euler-angle to pose-matrix pipeline.
// Holds the convention codes, register map and the Q60 sine series used to
// build the degree table at elaboration. No dependencies.
package eapm_pkg;

	// rotation conventions selected by the convention register
	typedef enum logic [1:0] {
		CONV_ZYX_EXT = 2'd0,
		CONV_ZYX_INT = 2'd1,
		CONV_ZYZ_EXT = 2'd2,
		CONV_ZYZ_INT = 2'd3
	} conv_t;

	localparam int TRIG_FRAC_BITS_DEF = 14;
	localparam int OUT_FRAC           = 14;
	localparam int OUT_ONE            = 16384;

	localparam int ANGLE_W = 10;
	localparam int SHIFT_W = 16;
	localparam int ROT_W   = 16;

	// register map
	localparam int PADDR_W        = 3;
	localparam int PDATA_W        = 32;
	localparam int REG_CONVENTION = 0;

	// degree table covers one quadrant
	localparam int SIN_LAST = 90;
	localparam int SIN_IDX_W = 7;

	localparam logic [63:0] PI_Q60       = 64'h3243F6A8885A308D;
	localparam logic [63:0] DEG_STEP_Q60 = PI_Q60 / 64'd180;

	// (a*b) >> 60 for unsigned Q60 operands
	function automatic logic [63:0] mul_q60(input logic [63:0] a, input logic [63:0] b);
		logic [127:0] p;
		p = {64'd0, a} * {64'd0, b};
		return p[123:60];
	endfunction

	// divide a series term by k*(k+1)
	function automatic logic [63:0] series_div(input logic [63:0] t, input int k);
		logic [63:0] r;
		case (k)
			2:       r = t / 64'd6;
			4:       r = t / 64'd20;
			6:       r = t / 64'd42;
			8:       r = t / 64'd72;
			10:      r = t / 64'd110;
			12:      r = t / 64'd156;
			14:      r = t / 64'd210;
			16:      r = t / 64'd272;
			18:      r = t / 64'd342;
			20:      r = t / 64'd420;
			22:      r = t / 64'd506;
			24:      r = t / 64'd600;
			26:      r = t / 64'd702;
			28:      r = t / 64'd812;
			30:      r = t / 64'd930;
			32:      r = t / 64'd1056;
			34:      r = t / 64'd1190;
			36:      r = t / 64'd1332;
			38:      r = t / 64'd1482;
			40:      r = t / 64'd1640;
			42:      r = t / 64'd1806;
			44:      r = t / 64'd1980;
			46:      r = t / 64'd2162;
			48:      r = t / 64'd2352;
			50:      r = t / 64'd2550;
			52:      r = t / 64'd2756;
			54:      r = t / 64'd2970;
			56:      r = t / 64'd3192;
			58:      r = t / 64'd3422;
			default: r = 64'd0;
		endcase
		return r;
	endfunction

	// sin(d degrees) in unsigned Q60 by Taylor series, elaboration only
	function automatic logic [63:0] sin_q60(input int d);
		logic [63:0] x;
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] sum;
		logic        neg;
		int          k;
		x    = 64'(d) * DEG_STEP_Q60;
		x2   = mul_q60(x, x);
		term = x;
		sum  = x;
		neg  = 1'b1;
		for (k = 2; k < 60; k += 2) begin
			if (term != 64'd0) begin
				term = series_div(mul_q60(term, x2), k);
				if (neg) begin
					sum = sum - term;
				end else begin
					sum = sum + term;
				end
				neg = !neg;
			end
		end
		return sum;
	endfunction

endpackage

>>> rtl/euler_angles_to_pose_matrix.sv
// Euler / Tait-Bryan angles to homogeneous pose matrix, eight-stage pipeline.
// Throughput: one item per cycle while the output is not stalled; the two multiplier ranks set the depth.
// A stalled output holds only the stages that are full; bubbles still advance.
// Reset clears the stage valid bits and sets convention to ZYX extrinsic.
// Depends on eapm_pkg for codes, widths and the sine series.
module euler_angles_to_pose_matrix #(
	parameter int TRIG_FRAC_BITS = eapm_pkg::TRIG_FRAC_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	// configuration
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [eapm_pkg::PADDR_W-1:0]        paddr,
	input  logic [eapm_pkg::PDATA_W-1:0]        pwdata,
	output logic [eapm_pkg::PDATA_W-1:0]        prdata,
	output logic                                pready,
	// angle and translation input
	input  logic                                item_valid,
	output logic                                item_stall,
	input  logic signed [eapm_pkg::ANGLE_W-1:0] angle_phi,
	input  logic signed [eapm_pkg::ANGLE_W-1:0] angle_theta,
	input  logic signed [eapm_pkg::ANGLE_W-1:0] angle_psi,
	input  logic signed [eapm_pkg::SHIFT_W-1:0] shift_x,
	input  logic signed [eapm_pkg::SHIFT_W-1:0] shift_y,
	input  logic signed [eapm_pkg::SHIFT_W-1:0] shift_z,
	// pose output
	output logic                                pose_valid,
	input  logic                                pose_stall,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_n_x,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_n_y,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_n_z,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_o_x,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_o_y,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_o_z,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_a_x,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_a_y,
	output logic signed [eapm_pkg::ROT_W-1:0]   rot_a_z,
	output logic signed [eapm_pkg::SHIFT_W-1:0] pos_x,
	output logic signed [eapm_pkg::SHIFT_W-1:0] pos_y,
	output logic signed [eapm_pkg::SHIFT_W-1:0] pos_z
);

	localparam int F  = TRIG_FRAC_BITS;
	localparam int TW = F + 2;          // trig value and rounded product
	localparam int PW = 2 * F + 2;      // raw product
	localparam int SW = F + 3;          // matrix entry before rescale
	localparam int DN = (F > eapm_pkg::OUT_FRAC) ? F - eapm_pkg::OUT_FRAC : 1;
	localparam int UP = (F < eapm_pkg::OUT_FRAC) ? eapm_pkg::OUT_FRAC - F : 0;
	localparam int RW = SW + UP;
	localparam int NSTG = 8;
	localparam int IW = eapm_pkg::SIN_IDX_W;

	localparam logic [PW-1:0] HALF_P = PW'(1) << (F - 1);
	localparam logic [SW-1:0] HALF_O = SW'(1) << (DN - 1);

	// trig slots: sin/cos of phi, theta, psi
	localparam int T_SP = 0;
	localparam int T_CP = 1;
	localparam int T_ST = 2;
	localparam int T_CT = 3;
	localparam int T_SS = 4;
	localparam int T_CS = 5;

	// ---------------------------------------------------------------------
	// configuration register
	// ---------------------------------------------------------------------
	eapm_pkg::conv_t conv_q;
	logic            reg_idx;

	assign reg_idx = paddr[2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conv_q <= eapm_pkg::CONV_ZYX_EXT;
		end else if (psel && penable && pwrite && pready &&
		             reg_idx == 1'(eapm_pkg::REG_CONVENTION)) begin
			conv_q <= eapm_pkg::conv_t'(pwdata[1:0]);
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == 1'(eapm_pkg::REG_CONVENTION)) begin
			prdata[1:0] = conv_q;
		end
	end

	// ---------------------------------------------------------------------
	// sine table, one quadrant, rounded from Q60 at elaboration
	// ---------------------------------------------------------------------
	logic [TW-1:0] sin_rom [0:eapm_pkg::SIN_LAST];

	for (genvar d = 0; d <= eapm_pkg::SIN_LAST; d++) begin : g_rom
		localparam logic [63:0] SQ = eapm_pkg::sin_q60(d);
		localparam logic [63:0] SR = (SQ + (64'd1 << (59 - F))) >> (60 - F);
		assign sin_rom[d] = SR[TW-1:0];
	end

	// ---------------------------------------------------------------------
	// handshake: a stage loads when it is empty or its successor moves
	// ---------------------------------------------------------------------
	logic [NSTG:1]   vld_s;
	logic [NSTG+1:1] rdy;

	always_comb begin
		rdy[NSTG+1] = !pose_stall;
		for (int k = NSTG; k >= 1; k--) begin
			rdy[k] = !vld_s[k] || rdy[k+1];
		end
	end

	assign item_stall = !rdy[1];
	assign pose_valid = vld_s[NSTG];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else begin
			if (rdy[1]) begin
				vld_s[1] <= item_valid;
			end
			for (int k = 2; k <= NSTG; k++) begin
				if (rdy[k]) begin
					vld_s[k] <= vld_s[k-1];
				end
			end
		end
	end

	// ---------------------------------------------------------------------
	// helpers
	// ---------------------------------------------------------------------
	// angle modulo 360, result 0..359
	function automatic logic [8:0] red360(input logic signed [eapm_pkg::ANGLE_W-1:0] d);
		logic [10:0] u;
		u = 11'(d) + 11'd720;
		if (u >= 11'd1080) begin
			u = u - 11'd1080;
		end else if (u >= 11'd720) begin
			u = u - 11'd720;
		end else if (u >= 11'd360) begin
			u = u - 11'd360;
		end
		return u[8:0];
	endfunction

	// quadrant fold: {negate, table index}
	function automatic logic [IW:0] qfold(input logic [8:0] r);
		logic [IW:0] f;
		if (r <= 9'd90) begin
			f = {1'b0, r[IW-1:0]};
		end else if (r <= 9'd180) begin
			f = {1'b0, IW'(9'd180 - r)};
		end else if (r <= 9'd270) begin
			f = {1'b1, IW'(r - 9'd180)};
		end else begin
			f = {1'b1, IW'(9'd360 - r)};
		end
		return f;
	endfunction

	// cosine angle: r + 90 modulo 360
	function automatic logic [8:0] add90(input logic [8:0] r);
		logic [9:0] c;
		c = 10'(r) + 10'd90;
		if (c >= 10'd360) begin
			c = c - 10'd360;
		end
		return c[8:0];
	endfunction

	// round product by 2^F, ties away from zero
	function automatic logic signed [TW-1:0] rnd_prod(input logic signed [PW-1:0] v);
		logic          neg;
		logic [PW-1:0] mag;
		logic [PW-1:0] q;
		neg = v[PW-1];
		mag = neg ? PW'(-v) : PW'(v);
		q   = (mag + HALF_P) >> F;
		return neg ? -TW'(q) : TW'(q);
	endfunction

	// rescale to Q1.14 and clamp to plus or minus one
	function automatic logic [eapm_pkg::ROT_W-1:0] out_fix(input logic signed [SW-1:0] v);
		logic                 neg;
		logic [SW-1:0]        mag;
		logic [SW-1:0]        qd;
		logic signed [RW-1:0] q;
		neg = v[SW-1];
		mag = neg ? SW'(-v) : SW'(v);
		qd  = (mag + HALF_O) >> DN;
		if (F > eapm_pkg::OUT_FRAC) begin
			q = neg ? -RW'(qd) : RW'(qd);
		end else begin
			q = RW'(v) <<< UP;
		end
		if (q > RW'(eapm_pkg::OUT_ONE)) begin
			q = RW'(eapm_pkg::OUT_ONE);
		end else if (q < -RW'(eapm_pkg::OUT_ONE)) begin
			q = -RW'(eapm_pkg::OUT_ONE);
		end
		return q[eapm_pkg::ROT_W-1:0];
	endfunction

	// ---------------------------------------------------------------------
	// stage 1: reduce angles, fold into the table quadrant
	// ---------------------------------------------------------------------
	logic [IW:0]                            tref_nxt [6];
	logic [IW:0]                            tref_s1  [6];
	logic [2:0][eapm_pkg::SHIFT_W-1:0]      pos_s1;

	always_comb begin
		logic [8:0] rp;
		logic [8:0] rt;
		logic [8:0] rs;
		rp = red360(angle_phi);
		rt = red360(angle_theta);
		rs = red360(angle_psi);
		tref_nxt[T_SP] = qfold(rp);
		tref_nxt[T_CP] = qfold(add90(rp));
		tref_nxt[T_ST] = qfold(rt);
		tref_nxt[T_CT] = qfold(add90(rt));
		tref_nxt[T_SS] = qfold(rs);
		tref_nxt[T_CS] = qfold(add90(rs));
	end

	always_ff @(posedge clk) begin
		if (rdy[1]) begin
			tref_s1 <= tref_nxt;
			pos_s1  <= {shift_z, shift_y, shift_x};
		end
	end

	// ---------------------------------------------------------------------
	// stage 2: table read and sign
	// ---------------------------------------------------------------------
	logic signed [TW-1:0]              trig_s2 [6];
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s2;

	always_ff @(posedge clk) begin
		if (rdy[2]) begin
			for (int i = 0; i < 6; i++) begin
				trig_s2[i] <= tref_s1[i][IW] ? -sin_rom[tref_s1[i][IW-1:0]]
				                             : sin_rom[tref_s1[i][IW-1:0]];
			end
			pos_s2 <= pos_s1;
		end
	end

	// ---------------------------------------------------------------------
	// stage 3: first multiplier rank (4 leading pairs, 8 plain products)
	// ---------------------------------------------------------------------
	logic signed [TW-1:0] sp, cp, st, ct, ss, cs;
	logic signed [TW-1:0] opa [12];
	logic signed [TW-1:0] opb [12];
	logic signed [TW-1:0] opz [4];

	assign sp = trig_s2[T_SP];
	assign cp = trig_s2[T_CP];
	assign st = trig_s2[T_ST];
	assign ct = trig_s2[T_CT];
	assign ss = trig_s2[T_SS];
	assign cs = trig_s2[T_CS];

	always_comb begin
		case (conv_q)
			eapm_pkg::CONV_ZYX_EXT: begin
				opa = '{ss, cs, ss, cs, ct, cs, ss, ct, cs, ss, ss, cs};
				opb = '{st, st, st, st, cp, sp, sp, sp, cp, cp, ct, ct};
				opz = '{cp, cp, sp, sp};
			end
			eapm_pkg::CONV_ZYX_INT: begin
				opa = '{cp, sp, cp, sp, cp, sp, sp, cp, ct, sp, cp, ct};
				opb = '{st, st, st, st, ct, ct, cs, cs, ss, ss, ss, cs};
				opz = '{ss, ss, cs, cs};
			end
			eapm_pkg::CONV_ZYZ_EXT: begin
				opa = '{cs, ss, cs, ss, ss, cs, st, ss, cs, st, cs, ss};
				opb = '{ct, ct, ct, ct, sp, sp, cp, cp, cp, sp, st, st};
				opz = '{cp, cp, sp, sp};
			end
			eapm_pkg::CONV_ZYZ_INT: begin
				opa = '{cp, sp, cp, sp, sp, cp, st, sp, cp, st, cp, sp};
				opb = '{ct, ct, ct, ct, ss, ss, cs, cs, cs, ss, st, st};
				opz = '{cs, cs, ss, ss};
			end
			default: begin
				opa = '{default: '0};
				opb = '{default: '0};
				opz = '{default: '0};
			end
		endcase
	end

	logic signed [PW-1:0]              prod_s3 [12];
	logic signed [TW-1:0]              z_s3    [4];
	logic signed [TW-1:0]              st_s3, ct_s3;
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s3;

	always_ff @(posedge clk) begin
		if (rdy[3]) begin
			for (int i = 0; i < 12; i++) begin
				prod_s3[i] <= opa[i] * opb[i];
			end
			z_s3   <= opz;
			st_s3  <= st;
			ct_s3  <= ct;
			pos_s3 <= pos_s2;
		end
	end

	// ---------------------------------------------------------------------
	// stage 4: round first rank
	// ---------------------------------------------------------------------
	logic signed [TW-1:0]              pr_s4 [4];
	logic signed [TW-1:0]              m_s4  [8];
	logic signed [TW-1:0]              z_s4  [4];
	logic signed [TW-1:0]              st_s4, ct_s4;
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s4;

	always_ff @(posedge clk) begin
		if (rdy[4]) begin
			for (int i = 0; i < 4; i++) begin
				pr_s4[i] <= rnd_prod(prod_s3[i]);
			end
			for (int i = 0; i < 8; i++) begin
				m_s4[i] <= rnd_prod(prod_s3[i+4]);
			end
			z_s4   <= z_s3;
			st_s4  <= st_s3;
			ct_s4  <= ct_s3;
			pos_s4 <= pos_s3;
		end
	end

	// ---------------------------------------------------------------------
	// stage 5: second multiplier rank for the triple products
	// ---------------------------------------------------------------------
	logic signed [PW-1:0]              qraw_s5 [4];
	logic signed [TW-1:0]              m_s5    [8];
	logic signed [TW-1:0]              st_s5, ct_s5;
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s5;

	always_ff @(posedge clk) begin
		if (rdy[5]) begin
			for (int i = 0; i < 4; i++) begin
				qraw_s5[i] <= pr_s4[i] * z_s4[i];
			end
			m_s5   <= m_s4;
			st_s5  <= st_s4;
			ct_s5  <= ct_s4;
			pos_s5 <= pos_s4;
		end
	end

	// ---------------------------------------------------------------------
	// stage 6: round second rank
	// ---------------------------------------------------------------------
	logic signed [TW-1:0]              q_s6 [4];
	logic signed [TW-1:0]              m_s6 [8];
	logic signed [TW-1:0]              st_s6, ct_s6;
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s6;

	always_ff @(posedge clk) begin
		if (rdy[6]) begin
			for (int i = 0; i < 4; i++) begin
				q_s6[i] <= rnd_prod(qraw_s5[i]);
			end
			m_s6   <= m_s5;
			st_s6  <= st_s5;
			ct_s6  <= ct_s5;
			pos_s6 <= pos_s5;
		end
	end

	// ---------------------------------------------------------------------
	// stage 7: combine into the nine entries
	// ---------------------------------------------------------------------
	logic signed [SW-1:0] q [4];
	logic signed [SW-1:0] m [8];
	logic signed [SW-1:0] est, ect;
	logic signed [SW-1:0] ent [9];

	always_comb begin
		for (int i = 0; i < 4; i++) begin
			q[i] = SW'(q_s6[i]);
		end
		for (int i = 0; i < 8; i++) begin
			m[i] = SW'(m_s6[i]);
		end
		est = SW'(st_s6);
		ect = SW'(ct_s6);
		case (conv_q)
			eapm_pkg::CONV_ZYX_EXT: begin
				ent = '{m[0], q[0] - m[1], q[1] + m[2], m[3], q[2] + m[4],
				        q[3] - m[5], -est, m[6], m[7]};
			end
			eapm_pkg::CONV_ZYX_INT: begin
				ent = '{m[0], m[1], -est, q[0] - m[2], q[1] + m[3], m[4],
				        q[2] + m[5], q[3] - m[6], m[7]};
			end
			// both ZYZ forms share one shape, phi and psi swap roles
			eapm_pkg::CONV_ZYZ_EXT, eapm_pkg::CONV_ZYZ_INT: begin
				ent = '{q[0] - m[0], q[1] + m[1], -m[2], -q[2] - m[3], m[4] - q[3],
				        m[5], m[6], m[7], ect};
			end
			default: begin
				ent = '{default: '0};
			end
		endcase
	end

	logic signed [SW-1:0]              ent_s7 [9];
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s7;

	always_ff @(posedge clk) begin
		if (rdy[7]) begin
			ent_s7 <= ent;
			pos_s7 <= pos_s6;
		end
	end

	// ---------------------------------------------------------------------
	// stage 8: rescale, clamp, output register
	// ---------------------------------------------------------------------
	logic [eapm_pkg::ROT_W-1:0]        rot_s8 [9];
	logic [2:0][eapm_pkg::SHIFT_W-1:0] pos_s8;

	always_ff @(posedge clk) begin
		if (rdy[8]) begin
			for (int i = 0; i < 9; i++) begin
				rot_s8[i] <= out_fix(ent_s7[i]);
			end
			pos_s8 <= pos_s7;
		end
	end

	assign rot_n_x = rot_s8[0];
	assign rot_n_y = rot_s8[1];
	assign rot_n_z = rot_s8[2];
	assign rot_o_x = rot_s8[3];
	assign rot_o_y = rot_s8[4];
	assign rot_o_z = rot_s8[5];
	assign rot_a_x = rot_s8[6];
	assign rot_a_y = rot_s8[7];
	assign rot_a_z = rot_s8[8];
	assign pos_x   = pos_s8[0];
	assign pos_y   = pos_s8[1];
	assign pos_z   = pos_s8[2];

endmodule
